>>> rtl/ec_point_add_scalar_multiply_unit_defines.svh
// assertion macros shared by the point unit
`ifndef EC_POINT_ADD_SCALAR_MULTIPLY_UNIT_DEFINES_SVH
`define EC_POINT_ADD_SCALAR_MULTIPLY_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define EC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define EC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EC_ASSERT(lbl, clk, rstn, prop)
`define EC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/ecpa_pkg.sv
// types and constants of the elliptic curve point unit
`default_nettype none
package ecpa_pkg;
    localparam int COORD_W  = 9;
    localparam int SCALAR_W = 16;
    localparam int APB_W    = 32;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_MUL = 1'b1;

    localparam logic [1:0] ADDR_CURVE_A = 2'd0;

    typedef struct packed {
        logic                command;
        logic [COORD_W-1:0]  first_x;
        logic [COORD_W-1:0]  first_y;
        logic [COORD_W-1:0]  second_x;
        logic [COORD_W-1:0]  second_y;
        logic [SCALAR_W-1:0] scalar;
    } t_in_beat;

    typedef struct packed {
        logic [COORD_W-1:0] result_x;
        logic [COORD_W-1:0] result_y;
    } t_out_beat;

    typedef enum logic {
        TGT_RES,
        TGT_ACC
    } t_tgt;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RED,
        S_BEGIN,
        S_MCHK,
        S_ADD_CHK,
        S_DBL_T,
        S_DBL_A,
        S_DBL_B,
        S_DBL_C,
        S_GEN,
        S_INV_INIT,
        S_INV_CHK,
        S_INV_MUL,
        S_INV_SQR,
        S_SLOPE,
        S_SQ,
        S_RX1,
        S_RX2,
        S_V,
        S_W,
        S_RY,
        S_WB,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

>>> rtl/ecpa_mul.sv
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
`default_nettype none
module ecpa_mul import ecpa_pkg::*; #(
    parameter int FIELD_PRIME = 263,
    parameter int W           = 9,
    parameter int AW          = 9
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [AW-1:0] i_a,
    input  wire logic [W-1:0]  i_b,
    output logic               o_done,
    output logic [W-1:0]       o_prod
);
    localparam int CW = $clog2(AW + 1);
    localparam logic [W:0] PRIME = (W+1)'(FIELD_PRIME);

    logic [AW-1:0] r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [W:0]   dbl;
    logic [W-1:0] dbl_red;
    logic [W:0]   sum;
    logic [W-1:0] n_acc;

    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= PRIME) ? W'(dbl - PRIME) : dbl[W-1:0];
        sum     = {1'b0, dbl_red} + (r_a[AW-1] ? {1'b0, r_b} : '0);
        n_acc   = (sum >= PRIME) ? W'(sum - PRIME) : sum[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(AW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_a   <= r_a << 1;
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule
`default_nettype wire

>>> rtl/ecpa_seq.sv
// point add and double-and-add sequencer around the serial multiplier
`default_nettype none
`include "ec_point_add_scalar_multiply_unit_defines.svh"
module ecpa_seq import ecpa_pkg::*; #(
    parameter int FIELD_PRIME = 263,
    parameter int SCALAR_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire t_in_beat           i_item,
    input  wire logic [COORD_W-1:0] i_curve_a,
    input  wire logic               i_take,
    output logic                    o_busy,
    output logic                    o_done,
    output t_out_beat               o_res
);
    localparam int W  = $clog2(FIELD_PRIME);
    localparam int AW = (W > COORD_W) ? W : COORD_W;
    localparam logic [W:0]   PRIME    = (W+1)'(FIELD_PRIME);
    localparam logic [W-1:0] EXP      = W'(FIELD_PRIME - 2);
    localparam logic [2:0]   RED_LAST = 3'd4;

    function automatic logic [W-1:0] f_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= PRIME) s = s - PRIME;
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] f_sub(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        if (a >= b) s = {1'b0, a} - {1'b0, b};
        else        s = {1'b0, a} + PRIME - {1'b0, b};
        return s[W-1:0];
    endfunction

    t_state r_state, n_state;
    t_in_beat r_item;
    t_tgt   r_tgt;
    logic   r_issued;
    logic   r_kadd;
    logic [2:0] r_ri;
    logic [SCALAR_BITS-1:0] r_k;
    logic [W-1:0] r_px, r_py, r_qx, r_qy, r_ca;
    logic [W-1:0] r_resx, r_resy, r_accx, r_accy;
    logic [W-1:0] r_o1x, r_o1y, r_o2x, r_o2y;
    logic [W-1:0] r_t, r_u, r_den, r_ir, r_ib, r_e, r_s, r_rx, r_ry;

    logic          mul_state;
    logic          mul_go;
    logic [AW-1:0] mul_a;
    logic [W-1:0]  mul_b;
    logic          mul_done;
    logic [W-1:0]  mul_p;
    logic          inf1, inf2, xeq, opp;

    ecpa_mul #(
        .FIELD_PRIME(FIELD_PRIME),
        .W          (W),
        .AW         (AW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mul_go),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_done (mul_done),
        .o_prod (mul_p)
    );

    always_comb begin
        inf1 = (r_o1x == '0) && (r_o1y == '0);
        inf2 = (r_o2x == '0) && (r_o2y == '0);
        xeq  = (r_o1x == r_o2x);
        opp  = xeq && (r_o1y == f_sub('0, r_o2y));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_start) n_state = S_RED;
            S_RED:      if (mul_done && r_ri == RED_LAST) n_state = S_BEGIN;
            S_BEGIN:    n_state = (r_item.command == CMD_ADD) ? S_ADD_CHK : S_MCHK;
            S_MCHK:     n_state = (r_k == '0) ? S_DONE : S_ADD_CHK;
            S_ADD_CHK: begin
                priority if (inf1 || inf2 || opp) n_state = S_WB;
                else if (xeq)                     n_state = S_DBL_T;
                else                              n_state = S_GEN;
            end
            S_DBL_T:    if (mul_done) n_state = S_DBL_A;
            S_DBL_A:    n_state = S_DBL_B;
            S_DBL_B:    n_state = S_DBL_C;
            S_DBL_C:    n_state = S_INV_INIT;
            S_GEN:      n_state = S_INV_INIT;
            S_INV_INIT: n_state = S_INV_CHK;
            S_INV_CHK: begin
                priority if (r_e == '0) n_state = S_SLOPE;
                else if (r_e[0])        n_state = S_INV_MUL;
                else                    n_state = S_INV_SQR;
            end
            S_INV_MUL:  if (mul_done) n_state = S_INV_SQR;
            S_INV_SQR:  if (mul_done) n_state = S_INV_CHK;
            S_SLOPE:    if (mul_done) n_state = S_SQ;
            S_SQ:       if (mul_done) n_state = S_RX1;
            S_RX1:      n_state = S_RX2;
            S_RX2:      n_state = S_V;
            S_V:        n_state = S_W;
            S_W:        if (mul_done) n_state = S_RY;
            S_RY:       n_state = S_WB;
            S_WB:       n_state = (r_item.command == CMD_ADD) ? S_DONE : S_MCHK;
            S_DONE:     if (i_take) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        mul_state = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (r_state)
            S_RED: begin
                mul_state = 1'b1;
                mul_b     = W'(1);
                unique case (r_ri)
                    3'd0:    mul_a = AW'(r_item.first_x);
                    3'd1:    mul_a = AW'(r_item.first_y);
                    3'd2:    mul_a = AW'(r_item.second_x);
                    3'd3:    mul_a = AW'(r_item.second_y);
                    default: mul_a = AW'(i_curve_a);
                endcase
            end
            S_DBL_T: begin
                mul_state = 1'b1;
                mul_a     = AW'(r_o1x);
                mul_b     = r_o1x;
            end
            S_INV_MUL: begin
                mul_state = 1'b1;
                mul_a     = AW'(r_ir);
                mul_b     = r_ib;
            end
            S_INV_SQR: begin
                mul_state = 1'b1;
                mul_a     = AW'(r_ib);
                mul_b     = r_ib;
            end
            S_SLOPE: begin
                mul_state = 1'b1;
                mul_a     = AW'(r_t);
                mul_b     = r_ir;
            end
            S_SQ: begin
                mul_state = 1'b1;
                mul_a     = AW'(r_s);
                mul_b     = r_s;
            end
            S_W: begin
                mul_state = 1'b1;
                mul_a     = AW'(r_s);
                mul_b     = r_u;
            end
            default: begin
                mul_state = 1'b0;
            end
        endcase
        mul_go         = mul_state && !r_issued;
        o_busy         = (r_state != S_IDLE);
        o_done         = (r_state == S_DONE) && i_take;
        o_res.result_x = COORD_W'(r_resx);
        o_res.result_y = COORD_W'(r_resy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mul_go)        r_issued <= 1'b1;
            else if (mul_done) r_issued <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_item <= i_item;
                    r_ri   <= '0;
                end
            end
            S_RED: begin
                if (mul_done) begin
                    r_ri <= r_ri + 1'b1;
                    unique case (r_ri)
                        3'd0:    r_px <= mul_p;
                        3'd1:    r_py <= mul_p;
                        3'd2:    r_qx <= mul_p;
                        3'd3:    r_qy <= mul_p;
                        default: r_ca <= mul_p;
                    endcase
                end
            end
            S_BEGIN: begin
                if (r_item.command == CMD_ADD) begin
                    r_o1x  <= r_px;
                    r_o1y  <= r_py;
                    r_o2x  <= r_qx;
                    r_o2y  <= r_qy;
                    r_tgt  <= TGT_RES;
                end else begin
                    r_resx <= '0;
                    r_resy <= '0;
                    r_accx <= r_px;
                    r_accy <= r_py;
                    r_k    <= SCALAR_BITS'(r_item.scalar);
                    r_kadd <= 1'b0;
                end
            end
            S_MCHK: begin
                if (r_k[0] && !r_kadd) begin
                    r_o1x  <= r_resx;
                    r_o1y  <= r_resy;
                    r_tgt  <= TGT_RES;
                    r_kadd <= 1'b1;
                end else begin
                    r_o1x  <= r_accx;
                    r_o1y  <= r_accy;
                    r_tgt  <= TGT_ACC;
                end
                r_o2x <= r_accx;
                r_o2y <= r_accy;
            end
            S_ADD_CHK: begin
                priority if (inf1) begin
                    r_rx <= r_o2x;
                    r_ry <= r_o2y;
                end else if (inf2) begin
                    r_rx <= r_o1x;
                    r_ry <= r_o1y;
                end else if (opp) begin
                    r_rx <= '0;
                    r_ry <= '0;
                end else begin
                    r_rx <= r_rx;
                end
            end
            S_DBL_T: begin
                if (mul_done) begin
                    r_t <= mul_p;
                    r_u <= mul_p;
                end
            end
            S_DBL_A:    r_t <= f_add(r_t, r_u);
            S_DBL_B:    r_t <= f_add(r_t, r_u);
            S_DBL_C: begin
                r_t   <= f_add(r_t, r_ca);
                r_den <= f_add(r_o1y, r_o1y);
            end
            S_GEN: begin
                r_t   <= f_sub(r_o1y, r_o2y);
                r_den <= f_sub(r_o1x, r_o2x);
            end
            S_INV_INIT: begin
                r_ir <= W'(1);
                r_ib <= r_den;
                r_e  <= EXP;
            end
            S_INV_CHK:  r_e <= r_e;
            S_INV_MUL:  if (mul_done) r_ir <= mul_p;
            S_INV_SQR: begin
                if (mul_done) begin
                    r_ib <= mul_p;
                    r_e  <= r_e >> 1;
                end
            end
            S_SLOPE:    if (mul_done) r_s <= mul_p;
            S_SQ:       if (mul_done) r_u <= mul_p;
            S_RX1:      r_rx <= f_sub(r_u, r_o1x);
            S_RX2:      r_rx <= f_sub(r_rx, r_o2x);
            S_V:        r_u  <= f_sub(r_o1x, r_rx);
            S_W:        if (mul_done) r_u <= mul_p;
            S_RY:       r_ry <= f_sub(r_u, r_o1y);
            S_WB: begin
                if (r_tgt == TGT_RES) begin
                    r_resx <= r_rx;
                    r_resy <= r_ry;
                end else begin
                    r_accx <= r_rx;
                    r_accy <= r_ry;
                    r_k    <= r_k >> 1;
                    r_kadd <= 1'b0;
                end
            end
            S_DONE:     r_ri <= r_ri;
            default:    r_ri <= r_ri;
        endcase
    end

    `EC_ASSERT(a_start_idle, i_clk, i_rst_n, i_start |-> r_state == S_IDLE)
    `EC_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, r_state == S_IDLE)
    `EC_ASSERT(a_wb_reduced, i_clk, i_rst_n, (r_state == S_WB) |-> (r_rx < PRIME && r_ry < PRIME))
    `EC_ASSERT(a_done_in_mul, i_clk, i_rst_n, mul_done |-> (mul_state && r_issued))
endmodule
`default_nettype wire

>>> rtl/ec_point_add_scalar_multiply_unit.sv
// Affine point add and scalar multiply on y^2 = x^3 + a*x + b over GF(FIELD_PRIME), (0,0) is
// infinity. One item at a time; every field product runs through one bit-serial modular
// multiplier. An item first spends five products reducing its inputs and curve_a; a point
// addition costs about 2*clog2(FIELD_PRIME)+4 products (inversion by exponentiation dominates),
// and a scalar multiply up to 2*SCALAR_BITS point operations, ending after the highest set
// scalar bit. A finished result sits in an output register while the next item is accepted.
`default_nettype none
module ec_point_add_scalar_multiply_unit import ecpa_pkg::*; #(
    parameter int FIELD_PRIME = 263,
    parameter int SCALAR_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_beat          i_in_beat,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_beat              o_out_beat,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [1:0]        paddr,
    input  wire logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]       prdata,
    output logic                   pready
);
    logic [COORD_W-1:0] r_curve_a;
    logic               r_out_valid;
    t_out_beat          r_out_beat;
    logic               seq_busy;
    logic               seq_done;
    logic               take;
    t_out_beat          seq_res;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CURVE_A) ? APB_W'(r_curve_a) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_a <= COORD_W'(1);
        end else if (psel && penable && pwrite && paddr == ADDR_CURVE_A) begin
            r_curve_a <= pwdata[COORD_W-1:0];
        end
    end

    assign o_in_ready = !seq_busy;
    assign take       = !r_out_valid || i_out_ready;

    ecpa_seq #(
        .FIELD_PRIME(FIELD_PRIME),
        .SCALAR_BITS(SCALAR_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_in_valid && !seq_busy),
        .i_item   (i_in_beat),
        .i_curve_a(r_curve_a),
        .i_take   (take),
        .o_busy   (seq_busy),
        .o_done   (seq_done),
        .o_res    (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) r_out_beat <= seq_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;
endmodule
`default_nettype wire

>>> sim/tb_top.sv
// self-checking testbench for the elliptic curve point add and scalar multiply unit
`default_nettype none
module tb_top;
    import ecpa_pkg::*;

    localparam int PRIME = 263;
    localparam int SCALAR_USED = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD_CYCLES = 4000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in_beat i_in_beat;
    logic o_out_valid;
    logic i_out_ready;
    t_out_beat o_out_beat;
    logic psel;
    logic penable;
    logic pwrite;
    logic [1:0] paddr;
    logic [APB_W-1:0] pwdata;
    logic [APB_W-1:0] prdata;
    logic pready;

    ec_point_add_scalar_multiply_unit i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_beat(i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_beat(o_out_beat),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    t_out_beat expected_points[$];
    int unsigned model_curve_a;
    int error_count;
    int points_sent;
    int points_checked;
    int multiplies_sent;
    int curve_settings;
    bit idle_enable;
    bit long_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(8 * 12000000);
        $display("timeout with %0d results outstanding", expected_points.size());
        $display("Simulation FAILED");
        $finish;
    end

    // field arithmetic for the predictor
    function automatic int unsigned mod_prime(input longint unsigned v);
        return int'(v % PRIME);
    endfunction

    function automatic int unsigned field_mul(input int unsigned u, input int unsigned v);
        return mod_prime(longint'(u) * longint'(v));
    endfunction

    function automatic int unsigned field_sub(input int unsigned u, input int unsigned v);
        return mod_prime(longint'(u) + PRIME - v);
    endfunction

    function automatic int unsigned field_inverse(input int unsigned v);
        int unsigned res;
        int unsigned base;
        int unsigned e;
        res = 1;
        base = mod_prime(v);
        e = PRIME - 2;
        while (e != 0) begin
            if (e & 1) res = field_mul(res, base);
            base = field_mul(base, base);
            e = e >> 1;
        end
        return res;
    endfunction

    function automatic void point_sum(input int unsigned px, input int unsigned py,
                                      input int unsigned qx, input int unsigned qy,
                                      output int unsigned rx, output int unsigned ry);
        int unsigned slope;
        int unsigned num;
        if (px == 0 && py == 0) begin
            rx = qx;
            ry = qy;
        end else if (qx == 0 && qy == 0) begin
            rx = px;
            ry = py;
        end else if (px == qx && py == field_sub(0, qy)) begin
            rx = 0;
            ry = 0;
        end else begin
            if (px == qx) begin
                num = mod_prime(3 * field_mul(px, px) + mod_prime(model_curve_a));
                slope = field_mul(num, field_inverse(mod_prime(2 * py)));
            end else begin
                slope = field_mul(field_sub(py, qy), field_inverse(field_sub(px, qx)));
            end
            rx = field_sub(field_sub(field_mul(slope, slope), px), qx);
            ry = field_sub(field_mul(slope, field_sub(px, rx)), py);
        end
    endfunction

    function automatic t_out_beat predict_point(input t_in_beat b);
        int unsigned px, py, qx, qy, rx, ry, ax, ay, tx, ty;
        t_out_beat r;
        px = mod_prime(b.first_x);
        py = mod_prime(b.first_y);
        qx = mod_prime(b.second_x);
        qy = mod_prime(b.second_y);
        if (b.command == CMD_MUL) begin
            rx = 0;
            ry = 0;
            ax = px;
            ay = py;
            for (int i = 0; i < SCALAR_USED; i++) begin
                if (b.scalar[i]) begin
                    point_sum(rx, ry, ax, ay, tx, ty);
                    rx = tx;
                    ry = ty;
                end
                point_sum(ax, ay, ax, ay, tx, ty);
                ax = tx;
                ay = ty;
            end
        end else begin
            point_sum(px, py, qx, qy, rx, ry);
        end
        r.result_x = rx[COORD_W-1:0];
        r.result_y = ry[COORD_W-1:0];
        return r;
    endfunction

    function automatic void enqueue_expected(input t_out_beat p);
        expected_points = {expected_points, p};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected result beat", 1, 0);
            end else begin
                want = expected_points.pop_front();
                points_checked++;
                if (o_out_beat.result_x !== want.result_x)
                    report_mismatch("result_x", o_out_beat.result_x, want.result_x);
                if (o_out_beat.result_y !== want.result_y)
                    report_mismatch("result_y", o_out_beat.result_y, want.result_y);
            end
        end
    end

    // receiver with random stalls and one long hold-off
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                long_hold_req = 1'b0;
                i_out_ready <= 1'b1;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_point_op(input t_in_beat b);
        @(negedge i_clk);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat <= b;
        do @(posedge i_clk); while (!o_in_ready);
        enqueue_expected(predict_point(b));
        points_sent++;
        if (b.command == CMD_MUL) multiplies_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_curve_a(input int unsigned value);
        wait_idle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_CURVE_A;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        model_curve_a = value & 9'h1FF;
        curve_settings++;
    endtask

    function automatic t_in_beat make_op(input logic cmd, input int fx, input int fy,
                                         input int sx, input int sy, input int k);
        t_in_beat b;
        b.command = cmd;
        b.first_x = fx[COORD_W-1:0];
        b.first_y = fy[COORD_W-1:0];
        b.second_x = sx[COORD_W-1:0];
        b.second_y = sy[COORD_W-1:0];
        b.scalar = k[SCALAR_W-1:0];
        return b;
    endfunction

    function automatic int random_coord();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 511);
        return $urandom_range(0, PRIME - 1);
    endfunction

    function automatic t_in_beat random_op();
        int fx, fy, sx, sy, k;
        fx = random_coord();
        fy = random_coord();
        sx = random_coord();
        sy = random_coord();
        case ($urandom_range(0, 9))
            0: begin sx = fx; sy = fy; end
            1: begin sx = fx; sy = (PRIME - fy % PRIME) % PRIME; end
            2: begin fx = 0; fy = 0; end
            3: sy = fy;
            default: ;
        endcase
        if ($urandom_range(0, 29) == 0) k = $urandom_range(0, 65535);
        else k = $urandom_range(0, 15);
        return make_op(1'($urandom_range(0, 1)), fx, fy, sx, sy, k);
    endfunction

    task automatic test_directed_adds();
        send_point_op(make_op(CMD_ADD, 5, 7, 11, 13, 0));
        send_point_op(make_op(CMD_ADD, 0, 0, 11, 13, 0));
        send_point_op(make_op(CMD_ADD, 5, 7, 0, 0, 0));
        send_point_op(make_op(CMD_ADD, 0, 0, 0, 0, 0));
        send_point_op(make_op(CMD_ADD, 5, 7, 5, PRIME - 7, 0));
        send_point_op(make_op(CMD_ADD, 9, 0, 9, 0, 0));
        send_point_op(make_op(CMD_ADD, 5, 7, 5, 7, 16'hFFFF));
        send_point_op(make_op(CMD_ADD, 5, 40, 100, 40, 0));
        send_point_op(make_op(CMD_ADD, 263, 263, 20, 30, 0));
        send_point_op(make_op(CMD_ADD, 511, 511, 511, 511, 0));
        send_point_op(make_op(CMD_ADD, 262, 262, 1, 1, 0));
        send_point_op(make_op(CMD_ADD, 268, 7, 5, 256, 0));
    endtask

    task automatic test_directed_multiplies();
        send_point_op(make_op(CMD_MUL, 5, 7, 0, 0, 0));
        send_point_op(make_op(CMD_MUL, 5, 7, 511, 511, 1));
        send_point_op(make_op(CMD_MUL, 5, 7, 0, 0, 2));
        send_point_op(make_op(CMD_MUL, 9, 0, 0, 0, 3));
        send_point_op(make_op(CMD_MUL, 0, 0, 0, 0, 16'hFFFF));
        send_point_op(make_op(CMD_MUL, 17, 23, 0, 0, 16'hFFFF));
        send_point_op(make_op(CMD_MUL, 262, 262, 0, 0, 16'h8000));
        send_point_op(make_op(CMD_MUL, 511, 300, 0, 0, 16'h5A5A));
    endtask

    task automatic test_curve_settings();
        int unsigned settings [4];
        settings = '{0, 262, 511, 7};
        foreach (settings[i]) begin
            write_curve_a(settings[i]);
            repeat (6) send_point_op(random_op());
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        long_hold_req = 1'b1;
        repeat (5) send_point_op(make_op(CMD_ADD, random_coord(), random_coord(),
                                         random_coord(), random_coord(), 0));
    endtask

    task automatic test_random_traffic(input int count);
        write_curve_a($urandom_range(0, PRIME - 1));
        repeat (count) send_point_op(random_op());
    endtask

    task automatic test_steady_stream(input int count);
        wait_idle();
        idle_enable = 1'b0;
        repeat (count) send_point_op(random_op());
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_beat = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        model_curve_a = 1;
        error_count = 0;
        points_sent = 0;
        points_checked = 0;
        multiplies_sent = 0;
        curve_settings = 0;
        idle_enable = 1'b1;
        long_hold_req = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_adds();
        test_directed_multiplies();
        test_curve_settings();
        test_backpressure();
        test_random_traffic(180);
        test_random_traffic(50);
        test_steady_stream(40);

        wait_idle();
        $display("covered %0d point operations (%0d scalar multiplies) under %0d curve settings",
                 points_sent, multiplies_sent, curve_settings);
        $display("checked %0d results, %0d mismatches", points_checked, error_count);
        if (error_count == 0 && expected_points.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl
rtl/ecpa_pkg.sv
rtl/ecpa_mul.sv
rtl/ecpa_seq.sv
rtl/ec_point_add_scalar_multiply_unit.sv
sim/tb_top.sv
